// ----- src/seg7s_pkg.sv -----
// seg7s_pkg: shared types, constants and the segment decode for the
// seven-segment scan stopwatch. No dependencies.

package seg7s_pkg;

   // default number of display positions
   localparam int DIGITS_DEFAULT = 4;

   // highest position count that has enable lines and text characters
   localparam int TEXT_POSITIONS = 4;

   // digit code for a dark position
   localparam logic [3:0] BLANK_CODE = 4'd15;

   // stopwatch limits and register reset
   localparam logic [13:0] WATCH_MAX    = 14'd9999;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   // ascii digit range
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // request codes
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_REFRESH = 3'd1;
   localparam logic [2:0] REQ_START   = 3'd2;
   localparam logic [2:0] REQ_STOP    = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;
   localparam logic [2:0] REQ_LOAD    = 3'd5;

   // per-item control broadcast to every cell in the chain
   typedef struct packed {
      logic       tick_fire;   // stopwatch adds one second
      logic       count_wrap;  // that second wraps the count to zero
      logic       zero_all;    // stopwatch reset: all positions show 0
      logic       load;        // text load
      logic       refresh;     // advance the scan token
      logic [3:0] text_len;    // loaded text length
   } cell_ctrl_type;

   // segment pattern, bit0 a .. bit6 g
   function automatic logic [6:0] seg_decode(input logic [3:0] code);
      logic [6:0] seg;
      case (code)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h67;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

// ----- src/seg7s_cell.sv -----
// seg7s_cell: one display position. Holds its shown digit code, one decimal
// digit of the stopwatch count and its share of the scan token.
// Depends on seg7s_pkg.

module seg7s_cell #(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,     // an item is accepted
   input  seg7s_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]               text_char,
   input  logic                     carry_in,    // from the next lower decimal digit
   output logic                     carry_out,
   input  logic                     ok_in,       // text still all digits to the left
   output logic                     ok_out,
   input  logic                     token_in,    // scan token of the previous position
   output logic                     token_out,
   output logic [3:0]               code_sel     // own code while holding the token, else 0
);

   localparam logic [3:0] POS = INDEX[3:0];

   logic [3:0] code_ff, code_in;
   logic [3:0] bcd_ff, bcd_in;
   logic       token_ff, token_next_in;
   logic       is_digit;
   logic       in_text;
   logic       digit_here;

   // text check: this position takes a character only if all earlier ones were digits
   assign is_digit   = (text_char >= seg7s_pkg::CHAR_ZERO) && (text_char <= seg7s_pkg::CHAR_NINE);
   assign in_text    = POS < ctrl.text_len;
   assign digit_here = ok_in && in_text && is_digit;
   assign ok_out     = ok_in && (!in_text || is_digit);

   // decimal digit of the running count
   assign carry_out = carry_in && (bcd_ff == 4'd9);

   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.zero_all || (ctrl.tick_fire && ctrl.count_wrap)) begin
         bcd_in = 4'd0;
      end else if (ctrl.tick_fire && carry_in) begin
         bcd_in = (bcd_ff == 4'd9) ? 4'd0 : bcd_ff + 4'd1;
      end
   end

   // shown code
   always_comb begin
      code_in = code_ff;
      if (ctrl.zero_all) begin
         code_in = 4'd0;
      end else if (ctrl.tick_fire) begin
         code_in = bcd_in;
      end else if (ctrl.load) begin
         code_in = digit_here ? 4'(text_char - seg7s_pkg::CHAR_ZERO) : seg7s_pkg::BLANK_CODE;
      end
   end

   // scan token moves one position on refresh
   assign token_next_in = ctrl.refresh ? token_in : token_ff;
   assign token_out     = token_ff;
   assign code_sel      = token_ff ? code_ff : 4'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= seg7s_pkg::BLANK_CODE;
         bcd_ff   <= 4'd0;
         token_ff <= (INDEX == 0);
      end else if (advance) begin
         code_ff  <= code_in;
         bcd_ff   <= bcd_in;
         token_ff <= token_next_in;
      end
   end

endmodule

// ----- src/seg7_scan_stopwatch.sv -----
// seg7_scan_stopwatch: top level of the multiplexed seven-segment driver
// with seconds stopwatch. Depends on seg7s_pkg and seg7s_cell.

// For every item, the chain of position cells and the tick
// counter update in the clock edge that accepts the item, and the result
// (the held segment drive, enables and stopwatch state after that item) is
// shown from registers on the next cycle. A new item is taken in the same
// cycle the previous result is taken, so the block sustains one item per
// clock; only a stalled result channel holds off the input. The stopwatch
// keeps its count both in binary and as one decimal digit per cell, with the
// carry rippling from the rightmost cell, so no division is needed.

module seg7_scan_stopwatch #(
   parameter int DIGITS = seg7s_pkg::DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_char_first,
   input  logic [7:0]  req_char_second,
   input  logic [7:0]  req_char_third,
   input  logic [7:0]  req_char_fourth,
   input  logic [3:0]  req_char_count,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_segment_lines,
   output logic [3:0]  rsp_digit_enables,
   output logic        rsp_watch_running,
   output logic [13:0] rsp_watch_value,
   output logic        rsp_text_valid,
   // period register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int LIMIT   = (DIGITS < seg7s_pkg::TEXT_POSITIONS) ? DIGITS
                                                                  : seg7s_pkg::TEXT_POSITIONS;
   localparam logic [3:0] LIMIT_CODE = LIMIT[3:0];
   localparam int EN_LINES = LIMIT;

   logic                     accept;
   logic                     rsp_valid_ff;
   logic [15:0]              period_ff;
   logic [15:0]              ticks_ff, ticks_in;
   logic [13:0]              count_ff, count_in;
   logic                     on_ff, on_in;
   logic [6:0]               seg_hold_ff, seg_hold_in;
   logic [3:0]               en_hold_ff, en_hold_in;
   logic                     text_ok_ff, text_ok_in;
   logic [15:0]              period_eff;
   logic [15:0]              ticks_inc;
   logic                     is_tick;
   logic                     tick_fire;
   seg7s_pkg::cell_ctrl_type ctrl;
   logic [7:0]               chars [0:seg7s_pkg::TEXT_POSITIONS-1];
   logic [DIGITS:0]          carry;
   logic [DIGITS:0]          ok;
   logic [DIGITS-1:0]        token;
   logic [3:0]               code_sel [0:DIGITS-1];
   logic [3:0]               sel_code;

   // handshake: output register frees up in the cycle it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= seg7s_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // tick counting
   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign ticks_inc  = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
   assign is_tick    = req_type == seg7s_pkg::REQ_TICK;
   assign tick_fire  = is_tick && on_ff && (ticks_inc >= period_eff);

   // cell control
   always_comb begin
      ctrl.tick_fire  = tick_fire;
      ctrl.count_wrap = count_ff >= seg7s_pkg::WATCH_MAX;
      ctrl.zero_all   = req_type == seg7s_pkg::REQ_CLEAR;
      ctrl.load       = req_type == seg7s_pkg::REQ_LOAD;
      ctrl.refresh    = req_type == seg7s_pkg::REQ_REFRESH;
      ctrl.text_len   = req_char_count;
   end

   assign chars[0] = req_char_first;
   assign chars[1] = req_char_second;
   assign chars[2] = req_char_third;
   assign chars[3] = req_char_fourth;

   // chain ends: carry enters at the rightmost cell, text check at the leftmost
   assign carry[DIGITS] = 1'b1;
   assign ok[0]         = req_char_count <= LIMIT_CODE;

   // row of position cells
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      logic [7:0] cell_char;
      if (i < seg7s_pkg::TEXT_POSITIONS) begin : g_char
         assign cell_char = chars[i];
      end else begin : g_nochar
         assign cell_char = 8'd0;
      end

      seg7s_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (accept),
         .ctrl      (ctrl),
         .text_char (cell_char),
         .carry_in  (carry[i+1]),
         .carry_out (carry[i]),
         .ok_in     (ok[i]),
         .ok_out    (ok[i+1]),
         .token_in  (token[(i + DIGITS - 1) % DIGITS]),
         .token_out (token[i]),
         .code_sel  (code_sel[i])
      );
   end

   // code of the position under the scan token
   always_comb begin
      sel_code = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         sel_code = sel_code | code_sel[i];
      end
   end

   // next state of the held drive and stopwatch
   always_comb begin
      ticks_in    = ticks_ff;
      count_in    = count_ff;
      on_in       = on_ff;
      seg_hold_in = seg_hold_ff;
      en_hold_in  = en_hold_ff;
      text_ok_in  = 1'b0;
      case (req_type)
         seg7s_pkg::REQ_TICK: begin
            if (on_ff) begin
               ticks_in = tick_fire ? 16'd0 : ticks_inc;
               if (tick_fire) begin
                  count_in = ctrl.count_wrap ? 14'd0 : count_ff + 14'd1;
               end
            end
         end
         seg7s_pkg::REQ_REFRESH: begin
            en_hold_in = 4'd0;
            if (sel_code < 4'd10) begin
               seg_hold_in = seg7s_pkg::seg_decode(sel_code);
               for (int i = 0; i < EN_LINES; i++) begin
                  en_hold_in[i] = token[i];
               end
            end
         end
         seg7s_pkg::REQ_START: begin
            on_in    = 1'b1;
            ticks_in = 16'd0;
         end
         seg7s_pkg::REQ_STOP: begin
            on_in = 1'b0;
         end
         seg7s_pkg::REQ_CLEAR: begin
            count_in = 14'd0;
            on_in    = 1'b0;
            ticks_in = 16'd0;
         end
         seg7s_pkg::REQ_LOAD: begin
            text_ok_in = ok[DIGITS];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff    <= 16'd0;
         count_ff    <= 14'd0;
         on_ff       <= 1'b0;
         seg_hold_ff <= 7'd0;
         en_hold_ff  <= 4'd0;
         text_ok_ff  <= 1'b0;
      end else if (accept) begin
         ticks_ff    <= ticks_in;
         count_ff    <= count_in;
         on_ff       <= on_in;
         seg_hold_ff <= seg_hold_in;
         en_hold_ff  <= en_hold_in;
         text_ok_ff  <= text_ok_in;
      end
   end

   // result item
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_lines = {1'b0, seg_hold_ff};
   assign rsp_digit_enables = en_hold_ff;
   assign rsp_watch_running = on_ff;
   assign rsp_watch_value   = count_ff;
   assign rsp_text_valid    = text_ok_ff;

endmodule
